/* rtl/cpfa_pkg.sv */
// ----------------------------------------------------------------------------
// cpfa_pkg: shared types and constants for the page frame allocator
// Field widths, status codes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpfa_pkg;

   localparam int FRAME_COUNT_DEF = 256;

   localparam int FRAME_W     = 27;
   localparam int REQ_PAGES_W = 9;
   localparam int BLOCK_W     = 8;
   localparam int PAGE_W      = 8;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_SIZE = 2'd1,
      ST_NO_FIT    = 2'd2,
      ST_HEAD_FREE = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_INIT,
      DP_LOAD,
      DP_RD_CUR,
      DP_SKIP,
      DP_EXTEND,
      DP_JUMP,
      DP_UNLINK,
      DP_DETACH,
      DP_RESULT,
      DP_F_START,
      DP_F_STEP,
      DP_F_LINK,
      DP_F_HEAD,
      DP_PUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic     init_last;
      func_type func;
      logic     req_zero;
      logic     cur_nil;
      logic     walk_over;
      logic     frame_zero;
      logic     run_ext;
      logic     run_full;
      logic     nxt_nil;
      logic     steps_left;
      logic     block_bad;
      logic     block_head;
      logic     rsp_free;
   } dp_stat_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_A_CHK,
      S_A_CUR,
      S_A_RUN,
      S_A_UNLINK,
      S_A_DETACH,
      S_F_WALK,
      S_F_HEAD,
      S_DONE
   } ctrl_state_type;

endpackage

/* rtl/contiguous_page_frame_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_page_frame_allocator: first-fit page frame allocator
// Doubly linked free list over FRAME_COUNT frames; allocate takes the first
// run of consecutive free indices, free splices a block back onto the head.
//
//   port group  dir      handshake            word
//   req_        in       req_valid/req_ready  func, request_pages, block_start
//   rsp_        out      rsp_valid/rsp_ready  status, first_page, phys_frame
//   csr_        in       csr_valid/csr_ready  base_frame
//
// After reset the link memories are swept before the first request is
// taken. On allocate each list entry costs a read and an evaluate on the
// next-link memory port, and a run is followed one step at a time. Free
// follows the links of the block one at a time. One request is in work
// at a time; a finished word waits in the output register, and the next
// request is taken while it waits.
// ----------------------------------------------------------------------------
module contiguous_page_frame_allocator #(
   parameter int FRAME_COUNT = cpfa_pkg::FRAME_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [cpfa_pkg::REQ_PAGES_W-1:0]  req_request_pages,
   input  logic [cpfa_pkg::BLOCK_W-1:0]      req_block_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [cpfa_pkg::PAGE_W-1:0]       rsp_first_page,
   output logic [cpfa_pkg::FRAME_W-1:0]      rsp_phys_frame,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cpfa_pkg::FRAME_W-1:0]      csr_base_frame
);
   import cpfa_pkg::*;

   logic [FRAME_W-1:0] base_frame_ff;
   dp_cmd_type         cmd;
   dp_stat_type        stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_frame_ff <= '0;
      end else if (csr_valid) begin
         base_frame_ff <= csr_base_frame;
      end
   end

   cpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   cpfa_dpath #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .base_frame        (base_frame_ff),
      .req_func          (req_func),
      .req_request_pages (req_request_pages),
      .req_block_start   (req_block_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_first_page    (rsp_first_page),
      .rsp_phys_frame    (rsp_phys_frame)
   );

endmodule

/* rtl/cpfa_dpath.sv */
// ----------------------------------------------------------------------------
// cpfa_dpath: link memories, walk registers and result registers
// Holds the next and prev link memories (one write and one registered read
// port each), the free list head, the walk pointers and counters, and the
// result word. Executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module cpfa_dpath #(
   parameter int FRAME_COUNT = cpfa_pkg::FRAME_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cpfa_pkg::dp_cmd_type              cmd,
   output cpfa_pkg::dp_stat_type             stat,
   input  logic [cpfa_pkg::FRAME_W-1:0]      base_frame,
   input  logic                              req_func,
   input  logic [cpfa_pkg::REQ_PAGES_W-1:0]  req_request_pages,
   input  logic [cpfa_pkg::BLOCK_W-1:0]      req_block_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [cpfa_pkg::PAGE_W-1:0]       rsp_first_page,
   output logic [cpfa_pkg::FRAME_W-1:0]      rsp_phys_frame
);
   import cpfa_pkg::*;

   localparam int IW = $clog2(FRAME_COUNT);
   localparam int LW = $clog2(FRAME_COUNT + 1);
   localparam int VW = LW + 1;
   localparam int BW = (LW > BLOCK_W) ? LW : BLOCK_W;
   localparam logic [LW-1:0] NIL = LW'(FRAME_COUNT);

   // link memories
   logic [LW-1:0] next_link_ff [FRAME_COUNT];
   logic [LW-1:0] prev_link_ff [FRAME_COUNT];
   logic [LW-1:0] next_rd_ff;
   logic [LW-1:0] prev_rd_ff;

   logic          nx_we, pv_we, nx_re, pv_re;
   logic [IW-1:0] nx_wa, pv_wa, nx_ra, pv_ra;
   logic [LW-1:0] nx_wd, pv_wd;

   // control state
   logic [LW-1:0] head_ff;
   logic [IW-1:0] init_ff;
   logic          rsp_valid_ff;

   // walk and request registers
   logic [LW-1:0]          cur_ff;
   logic [LW-1:0]          run_ff;
   logic [REQ_PAGES_W-1:0] cnt_ff;
   logic [VW-1:0]          visits_ff;
   logic                   func_ff;
   logic [REQ_PAGES_W-1:0] pages_ff;
   logic [BLOCK_W-1:0]     block_ff;

   // result words
   status_type         res_status_ff;
   logic [PAGE_W-1:0]  res_page_ff;
   logic [FRAME_W-1:0] res_frame_ff;
   status_type         rsp_status_ff;
   logic [PAGE_W-1:0]  rsp_page_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;

   logic               is_head;
   logic [FRAME_W-1:0] frame_cur;

   assign is_head   = (cur_ff == head_ff);
   assign frame_cur = base_frame + FRAME_W'(cur_ff);

   always_comb begin
      stat.init_last  = (init_ff == IW'(FRAME_COUNT - 1));
      stat.func       = func_type'(func_ff);
      stat.req_zero   = (pages_ff == '0);
      stat.cur_nil    = (cur_ff == NIL);
      stat.walk_over  = (visits_ff >= VW'(FRAME_COUNT));
      stat.frame_zero = (frame_cur == '0);
      stat.nxt_nil    = (next_rd_ff == NIL);
      stat.run_ext    = (next_rd_ff != NIL) && (cnt_ff < pages_ff) &&
                        (next_rd_ff == run_ff + LW'(1));
      stat.run_full   = (cnt_ff == pages_ff);
      stat.steps_left = (visits_ff < VW'(FRAME_COUNT));
      stat.block_bad  = (BW'(block_ff) >= BW'(FRAME_COUNT));
      stat.block_head = (BW'(block_ff) == BW'(head_ff));
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // memory port steering
   always_comb begin
      nx_we = 1'b0;
      nx_wa = '0;
      nx_wd = '0;
      pv_we = 1'b0;
      pv_wa = '0;
      pv_wd = '0;
      nx_re = 1'b0;
      nx_ra = '0;
      pv_re = 1'b0;
      pv_ra = '0;
      case (cmd.op)
         DP_INIT: begin
            nx_we = 1'b1;
            nx_wa = init_ff;
            nx_wd = LW'(init_ff) + LW'(1);
            pv_we = 1'b1;
            pv_wa = init_ff;
            pv_wd = (init_ff == '0) ? NIL : LW'(init_ff) - LW'(1);
         end
         DP_RD_CUR: begin
            nx_re = 1'b1;
            nx_ra = cur_ff[IW-1:0];
            pv_re = 1'b1;
            pv_ra = cur_ff[IW-1:0];
         end
         DP_EXTEND, DP_F_STEP: begin
            nx_re = 1'b1;
            nx_ra = next_rd_ff[IW-1:0];
         end
         DP_F_START: begin
            nx_re = 1'b1;
            nx_ra = IW'(block_ff);
         end
         DP_UNLINK: begin
            // bridge the predecessor over the run, or move the head past it
            nx_we = !is_head && (prev_rd_ff != NIL);
            nx_wa = prev_rd_ff[IW-1:0];
            nx_wd = next_rd_ff;
            pv_we = (next_rd_ff != NIL);
            pv_wa = next_rd_ff[IW-1:0];
            pv_wd = is_head ? NIL : prev_rd_ff;
         end
         DP_DETACH: begin
            nx_we = 1'b1;
            nx_wa = run_ff[IW-1:0];
            nx_wd = NIL;
            pv_we = 1'b1;
            pv_wa = cur_ff[IW-1:0];
            pv_wd = NIL;
         end
         DP_F_LINK: begin
            nx_we = 1'b1;
            nx_wa = run_ff[IW-1:0];
            nx_wd = head_ff;
            pv_we = (head_ff != NIL);
            pv_wa = head_ff[IW-1:0];
            pv_wd = run_ff;
         end
         DP_F_HEAD: begin
            pv_we = 1'b1;
            pv_wa = IW'(block_ff);
            pv_wd = NIL;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (nx_we) begin
         next_link_ff[nx_wa] <= nx_wd;
      end
      if (pv_we) begin
         prev_link_ff[pv_wa] <= pv_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (nx_re) begin
         next_rd_ff <= next_link_ff[nx_ra];
      end
      if (pv_re) begin
         prev_rd_ff <= prev_link_ff[pv_ra];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == DP_PUSH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            DP_INIT:   init_ff <= init_ff + IW'(1);
            DP_UNLINK: begin
               if (is_head) begin
                  head_ff <= next_rd_ff;
               end
            end
            DP_F_HEAD: head_ff <= LW'(block_ff);
            default: begin
            end
         endcase
      end
   end

   // walk and result payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: begin
            func_ff   <= req_func;
            pages_ff  <= req_request_pages;
            block_ff  <= req_block_start;
            cur_ff    <= head_ff;
            visits_ff <= '0;
         end
         DP_RD_CUR: begin
            run_ff <= cur_ff;
            cnt_ff <= REQ_PAGES_W'(1);
         end
         DP_SKIP: begin
            cur_ff    <= next_rd_ff;
            visits_ff <= visits_ff + VW'(1);
         end
         DP_EXTEND: begin
            run_ff <= next_rd_ff;
            cnt_ff <= cnt_ff + REQ_PAGES_W'(1);
         end
         DP_JUMP: begin
            // every start inside a failed run fails too: jump past it
            cur_ff    <= next_rd_ff;
            visits_ff <= visits_ff + VW'(cnt_ff);
         end
         DP_DETACH: begin
            res_status_ff <= ST_OK;
            res_page_ff   <= PAGE_W'(cur_ff);
            res_frame_ff  <= frame_cur;
         end
         DP_RESULT: begin
            res_status_ff <= cmd.status;
            res_page_ff   <= '0;
            res_frame_ff  <= '0;
         end
         DP_F_START: begin
            run_ff    <= LW'(block_ff);
            visits_ff <= '0;
         end
         DP_F_STEP: begin
            run_ff    <= next_rd_ff;
            visits_ff <= visits_ff + VW'(1);
         end
         DP_F_HEAD: begin
            res_status_ff <= ST_OK;
            res_page_ff   <= '0;
            res_frame_ff  <= '0;
         end
         DP_PUSH: begin
            rsp_status_ff <= res_status_ff;
            rsp_page_ff   <= res_page_ff;
            rsp_frame_ff  <= res_frame_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_first_page = rsp_page_ff;
   assign rsp_phys_frame = rsp_frame_ff;

   a_no_nil_follow: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_EXTEND || cmd.op == DP_F_STEP) |-> next_rd_ff != NIL)
      else $error("walk follows a null link");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_PUSH |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten before it was taken");

   a_detach_fit: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_DETACH |-> (cnt_ff == pages_ff && frame_cur != '0))
      else $error("run detached without a full fit");

   a_free_not_head: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_F_HEAD |-> BW'(block_ff) != BW'(head_ff))
      else $error("current head spliced onto itself");

endmodule

/* rtl/cpfa_ctrl.sv */
// ----------------------------------------------------------------------------
// cpfa_ctrl: sequencer for the page frame allocator
// Runs the reset sweep, takes one request at a time, steps the datapath
// through the list walk and relinking, and hands the result word over.
// ----------------------------------------------------------------------------
module cpfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output cpfa_pkg::dp_cmd_type  cmd,
   input  cpfa_pkg::dp_stat_type stat
);
   import cpfa_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (stat.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.func)
               FUNC_ALLOC: state_in = stat.req_zero ? S_DONE : S_A_CHK;
               FUNC_FREE: begin
                  state_in = (stat.block_bad || stat.block_head) ? S_DONE : S_F_WALK;
               end
            endcase
         end
         S_A_CHK: begin
            state_in = (stat.cur_nil || stat.walk_over) ? S_DONE : S_A_CUR;
         end
         S_A_CUR, S_A_RUN: begin
            if (state_ff == S_A_CUR && stat.frame_zero) state_in = S_A_CHK;
            else if (stat.run_ext)                      state_in = S_A_RUN;
            else if (stat.run_full)                     state_in = S_A_UNLINK;
            else                                        state_in = S_A_CHK;
         end
         S_A_UNLINK: state_in = S_A_DETACH;
         S_A_DETACH: state_in = S_DONE;
         S_F_WALK: begin
            if (stat.nxt_nil)         state_in = S_F_HEAD;
            else if (!stat.steps_left) state_in = S_DONE;
         end
         S_F_HEAD: state_in = S_DONE;
         S_DONE: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // commands
   always_comb begin
      cmd.op     = DP_NOP;
      cmd.status = ST_OK;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_INIT: cmd.op = DP_INIT;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = DP_LOAD;
         end
         S_DECODE: begin
            unique case (stat.func)
               FUNC_ALLOC: begin
                  if (stat.req_zero) begin
                     cmd.op     = DP_RESULT;
                     cmd.status = ST_ZERO_SIZE;
                  end
               end
               FUNC_FREE: begin
                  if (stat.block_bad) begin
                     cmd.op     = DP_RESULT;
                     cmd.status = ST_NO_FIT;
                  end else if (stat.block_head) begin
                     cmd.op     = DP_RESULT;
                     cmd.status = ST_HEAD_FREE;
                  end else begin
                     cmd.op = DP_F_START;
                  end
               end
            endcase
         end
         S_A_CHK: begin
            if (stat.cur_nil || stat.walk_over) begin
               cmd.op     = DP_RESULT;
               cmd.status = ST_NO_FIT;
            end else begin
               cmd.op = DP_RD_CUR;
            end
         end
         S_A_CUR, S_A_RUN: begin
            // a start at frame number zero is passed over
            if (state_ff == S_A_CUR && stat.frame_zero) cmd.op = DP_SKIP;
            else if (stat.run_ext)                      cmd.op = DP_EXTEND;
            else if (!stat.run_full)                    cmd.op = DP_JUMP;
         end
         S_A_UNLINK: cmd.op = DP_UNLINK;
         S_A_DETACH: cmd.op = DP_DETACH;
         S_F_WALK: begin
            if (stat.nxt_nil) begin
               cmd.op = DP_F_LINK;
            end else if (stat.steps_left) begin
               cmd.op = DP_F_STEP;
            end else begin
               // block never ends: drop the free
               cmd.op     = DP_RESULT;
               cmd.status = ST_NO_FIT;
            end
         end
         S_F_HEAD: cmd.op = DP_F_HEAD;
         S_DONE: begin
            if (stat.rsp_free) cmd.op = DP_PUSH;
         end
         default: begin
         end
      endcase
   end

   a_ready_idle_only: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff != S_INIT && cmd.op != DP_PUSH)
      else $error("request taken while busy");

   a_load_to_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_LOAD |=> state_ff == S_DECODE)
      else $error("loaded request not decoded");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !stat.rsp_free) |=> state_ff == S_DONE)
      else $error("result dropped while output word busy");

endmodule

/* verif/tb_contiguous_page_frame_allocator.sv */
// ----------------------------------------------------------------------------
// tb_contiguous_page_frame_allocator: self-checking bench for the allocator
// Drives allocate and free requests under random sender gaps and receiver
// stalls. A behavioral copy of the free list predicts every response word,
// and each accepted response is checked in order against that prediction.
// Covers size extremes, empty list, zero-frame skip, back-pressure and
// long random traffic under several base frame settings.
// ----------------------------------------------------------------------------
module tb_contiguous_page_frame_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import cpfa_pkg::*;

   localparam int FRAMES = FRAME_COUNT_DEF;
   localparam logic [8:0] NIL_IDX = 9'(FRAMES);
   localparam logic [FRAME_W-1:0] BASE_MAX = {FRAME_W{1'b1}};
   localparam int DRAIN_CYCLES = 2 * FRAMES + 16;

   typedef struct packed {
      status_type              status;
      logic [PAGE_W-1:0]       first_page;
      logic [FRAME_W-1:0]      phys_frame;
   } frame_grant_type;

   typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_TIGHT} rx_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_func = 1'b0;
   logic [REQ_PAGES_W-1:0]   req_request_pages = '0;
   logic [BLOCK_W-1:0]       req_block_start = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_status;
   logic [PAGE_W-1:0]        rsp_first_page;
   logic [FRAME_W-1:0]       rsp_phys_frame;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [FRAME_W-1:0]       csr_base_frame = '0;

   // free list mirror
   logic [8:0]               succ_idx [FRAMES];
   logic [8:0]               pred_idx [FRAMES];
   logic [8:0]               list_head;
   logic [FRAME_W-1:0]       frame_base;

   frame_grant_type          grant_queue [$];
   int                       owned_blocks [$];
   int                       mismatches = 0;
   int                       burst_left = 0;
   int                       rsp_hold_cycles = 0;
   int                       rx_left = 0;
   rx_mode_type              rx_mode = RX_OPEN;

   contiguous_page_frame_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_request_pages (req_request_pages),
      .req_block_start   (req_block_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_first_page    (rsp_first_page),
      .rsp_phys_frame    (rsp_phys_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_base_frame    (csr_base_frame)
   );

   always #5 clock = ~clock;

   function automatic void clear_free_list();
      for (int i = 0; i < FRAMES; i++) begin
         succ_idx[i] = (i == FRAMES - 1) ? NIL_IDX : 9'(i + 1);
         pred_idx[i] = (i == 0) ? NIL_IDX : 9'(i - 1);
      end
      list_head  = '0;
      frame_base = '0;
   endfunction

   function automatic logic [FRAME_W-1:0] frame_num(int idx);
      return frame_base + FRAME_W'(idx);
   endfunction

   function automatic frame_grant_type take_first_fit(int pages);
      frame_grant_type g;
      int cur, visits, run_end, cnt, after, back;
      g = '{status: ST_NO_FIT, first_page: '0, phys_frame: '0};
      if (pages == 0) begin
         g.status = ST_ZERO_SIZE;
         return g;
      end
      cur = list_head;
      visits = 0;
      while (cur != NIL_IDX && visits < FRAMES) begin
         visits++;
         // a start that maps to frame zero is never handed out
         if (frame_num(cur) == '0) begin
            cur = succ_idx[cur];
            continue;
         end
         run_end = cur;
         cnt = 1;
         while (succ_idx[run_end] != NIL_IDX && cnt < pages &&
                int'(succ_idx[run_end]) == run_end + 1) begin
            run_end = succ_idx[run_end];
            cnt++;
         end
         if (cnt == pages) begin
            after = succ_idx[run_end];
            if (cur == list_head) begin
               list_head = 9'(after);
               if (after != NIL_IDX) pred_idx[after] = NIL_IDX;
            end else begin
               back = pred_idx[cur];
               if (back != NIL_IDX) succ_idx[back] = 9'(after);
               if (after != NIL_IDX) pred_idx[after] = 9'(back);
            end
            pred_idx[cur] = NIL_IDX;
            succ_idx[run_end] = NIL_IDX;
            g.status = ST_OK;
            g.first_page = PAGE_W'(cur);
            g.phys_frame = frame_num(cur);
            return g;
         end
         cur = succ_idx[cur];
      end
      return g;
   endfunction

   function automatic frame_grant_type return_block(int start);
      frame_grant_type g;
      int last, steps;
      g = '{status: ST_OK, first_page: '0, phys_frame: '0};
      if (start >= FRAMES) begin
         g.status = ST_NO_FIT;
         return g;
      end
      if (start == list_head) begin
         g.status = ST_HEAD_FREE;
         return g;
      end
      last = start;
      steps = 0;
      while (succ_idx[last] != NIL_IDX && steps < FRAMES) begin
         last = succ_idx[last];
         steps++;
      end
      if (succ_idx[last] != NIL_IDX) begin
         g.status = ST_NO_FIT;
         return g;
      end
      succ_idx[last] = list_head;
      if (list_head != NIL_IDX) pred_idx[list_head] = 9'(last);
      list_head = 9'(start);
      pred_idx[start] = NIL_IDX;
      return g;
   endfunction

   // Offer one word, hold it until taken, then predict its response.
   task automatic send_request(input func_type op, input logic [REQ_PAGES_W-1:0] pages,
                               input logic [BLOCK_W-1:0] start);
      frame_grant_type g;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_func          <= op;
      req_request_pages <= pages;
      req_block_start   <= start;
      do @(posedge clock); while (!req_ready);
      if (op == FUNC_ALLOC) begin
         g = take_first_fit(int'(pages));
         if (g.status == ST_OK) owned_blocks.push_back(int'(g.first_page));
      end else begin
         g = return_block(int'(start));
         if (g.status == ST_OK) begin
            foreach (owned_blocks[i]) begin
               if (owned_blocks[i] == int'(start)) begin
                  owned_blocks.delete(i);
                  break;
               end
            end
         end
      end
      grant_queue.push_back(g);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (grant_queue.size() != 0) @(posedge clock);
   endtask

   task automatic set_base(input logic [FRAME_W-1:0] value);
      wait_idle();
      csr_valid      <= 1'b1;
      csr_base_frame <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      frame_base = value;
   endtask

   task automatic free_owned(input int pick);
      send_request(FUNC_FREE, REQ_PAGES_W'($urandom), BLOCK_W'(owned_blocks[pick]));
   endtask

   task automatic test_size_extremes();
      send_request(FUNC_ALLOC, 9'd0, 8'hFF);
      send_request(FUNC_ALLOC, 9'd511, 8'h00);
      send_request(FUNC_ALLOC, 9'd256, 8'hA5);
      send_request(FUNC_ALLOC, 9'd1, 8'h5A);
      free_owned(0);
      send_request(FUNC_FREE, 9'h1FF, BLOCK_W'(list_head));
   endtask

   task automatic test_empty_list();
      int run_len, p, blk;
      set_base(FRAME_W'(1));
      // take the run at the head until nothing is left
      for (int k = 0; k < 8 && list_head != NIL_IDX; k++) begin
         run_len = 1;
         p = list_head;
         while (succ_idx[p] != NIL_IDX && int'(succ_idx[p]) == p + 1) begin
            p++;
            run_len++;
         end
         send_request(FUNC_ALLOC, REQ_PAGES_W'(run_len), BLOCK_W'($urandom));
      end
      send_request(FUNC_ALLOC, 9'd1, 8'h00);
      blk = owned_blocks[0];
      free_owned(0);
      send_request(FUNC_FREE, 9'd0, BLOCK_W'(blk));
   endtask

   task automatic test_zero_frame_skip();
      set_base(BASE_MAX);
      if (owned_blocks.size() > 0) free_owned(0);
      send_request(FUNC_ALLOC, 9'd2, 8'h00);
      set_base(BASE_MAX - FRAME_W'(2));
      if (owned_blocks.size() > 0) free_owned(owned_blocks.size() - 1);
      send_request(FUNC_ALLOC, 9'd4, 8'h00);
   endtask

   task automatic test_backpressure();
      wait_idle();
      rsp_hold_cycles = 3000;
      send_request(FUNC_ALLOC, 9'd0, 8'h00);
      send_request(FUNC_ALLOC, 9'd0, 8'h00);
      send_request(FUNC_ALLOC, 9'd2, 8'h00);
      send_request(FUNC_ALLOC, 9'd0, 8'h00);
      if (owned_blocks.size() > 0) free_owned(0);
      send_request(FUNC_ALLOC, 9'd1, 8'h00);
   endtask

   task automatic run_mixed_traffic(input int count, input int noise_pct);
      int roll, pick, pages;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < noise_pct) begin
            // double frees, frees into a block, odd sizes
            case ($urandom_range(0, 2))
               0: send_request(FUNC_FREE, REQ_PAGES_W'($urandom),
                               BLOCK_W'($urandom_range(0, FRAMES - 1)));
               1: begin
                  if (owned_blocks.size() > 0) begin
                     pick = $urandom_range(0, owned_blocks.size() - 1);
                     send_request(FUNC_FREE, 9'd0, BLOCK_W'(owned_blocks[pick] + 1));
                  end else begin
                     send_request(FUNC_FREE, 9'd0, BLOCK_W'(list_head));
                  end
               end
               default: begin
                  pages = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 511);
                  send_request(FUNC_ALLOC, REQ_PAGES_W'(pages), BLOCK_W'($urandom));
               end
            endcase
         end else if (owned_blocks.size() > 0 && roll < 50 + noise_pct / 2) begin
            free_owned($urandom_range(0, owned_blocks.size() - 1));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 75) pages = $urandom_range(1, 8);
            else if (roll < 95) pages = $urandom_range(9, 48);
            else pages = $urandom_range(49, 256);
            send_request(FUNC_ALLOC, REQ_PAGES_W'(pages), BLOCK_W'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic();
      set_base('0);
      run_mixed_traffic(170, 4);
      set_base(BASE_MAX);
      run_mixed_traffic(170, 4);
      set_base(FRAME_W'($urandom));
      run_mixed_traffic(170, 4);
      set_base(BASE_MAX - FRAME_W'(127));
      run_mixed_traffic(170, 4);
      set_base(FRAME_W'($urandom));
      run_mixed_traffic(190, 30);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 200);
         end
         rx_left--;
         case (rx_mode)
            RX_OPEN:  rsp_ready <= 1'b1;
            RX_HALF:  rsp_ready <= 1'($urandom_range(0, 1));
            default:  rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      frame_grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (grant_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: status %0d first_page %0d phys_frame 0x%0h",
                        rsp_status, rsp_first_page, rsp_phys_frame);
         end else begin
            want = grant_queue.pop_front();
            if (rsp_status !== want.status || rsp_first_page !== want.first_page ||
                rsp_phys_frame !== want.phys_frame) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: status %0d/%0d first_page %0d/%0d %s",
                           $realtime, want.status, rsp_status, want.first_page,
                           rsp_first_page, $sformatf("phys_frame 0x%0h/0x%0h (exp/act)",
                           want.phys_frame, rsp_phys_frame));
            end
         end
      end
   end

   initial begin
      clear_free_list();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_size_extremes();
      test_empty_list();
      test_zero_frame_skip();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      // catch any stray word after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(30_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
